// ----- hw/rtl/tdp_pkg.sv -----
// shared constants and types for the trial-division prime test
// no dependencies
`timescale 1ns / 1ps

package tdp_pkg;

  // default width of the tested number
  localparam int VALUE_BITS_DEF = 16;

  // status from the remainder unit back to the sequencer
  typedef struct packed {
    logic done;
    logic zero;
  } rem_status_t;

endpackage

// ----- hw/rtl/trial_division_prime_test.sv -----
// trial-division primality test, top level with the divisor sequencer
// depends on tdp_pkg and tdp_rem
`timescale 1ns / 1ps

// One word in, one word out: pulse start while busy is low and the number on
// in_value is taken. The answer shows on out_is_prime, marked by out_valid for
// exactly one cycle; it cannot be held off, so catch it when it appears.
// Candidate divisors d = 2, 3, ... are tried while d*d <= value. Each trial
// runs through a bit-serial remainder unit, one dividend bit per shift, with
// a bound check and handoff in the sequencer. A prime near 2^VALUE_BITS takes
// the longest, as about sqrt(value) divisors are tried; an even number from
// four up finishes after one trial, and values below four need no trial.
// busy stays high from the accepted word until its answer is out.
module trial_division_prime_test import tdp_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  output logic                  out_is_prime
);

  // largest tested divisor is below 2^ceil(W/2); one more bit holds d after it
  localparam int DIV_BITS = (VALUE_BITS + 1) / 2 + 1;
  // running square of d, may run just past 2^W before the loop stops
  localparam int SQ_BITS  = VALUE_BITS + 2;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_DIV   = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [VALUE_BITS-1:0] value_r;
  logic [DIV_BITS-1:0]   d_r, d_nxt;
  logic [SQ_BITS-1:0]    sq_r, sq_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_is_prime_r, out_is_prime_nxt;
  logic                  rem_start;
  logic                  accept;
  rem_status_t           rem_status;

  assign accept = start && !busy;

  // remainder of value by the current candidate
  tdp_rem #(
    .VALUE_BITS (VALUE_BITS),
    .DIV_BITS   (DIV_BITS)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (value_r),
    .divisor  (d_r),
    .status   (rem_status)
  );

  always_comb begin
    state_nxt        = state_r;
    d_nxt            = d_r;
    sq_nxt           = sq_r;
    out_valid_nxt    = 1'b0;
    out_is_prime_nxt = out_is_prime_r;
    rem_start        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          // first candidate is two, square four
          d_nxt     = DIV_BITS'(2);
          sq_nxt    = SQ_BITS'(4);
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (value_r < VALUE_BITS'(2)) begin
          // zero and one are not prime
          out_valid_nxt    = 1'b1;
          out_is_prime_nxt = 1'b0;
          state_nxt        = S_IDLE;
        end else if (sq_r > SQ_BITS'(value_r)) begin
          // ran past the root with no divisor found
          out_valid_nxt    = 1'b1;
          out_is_prime_nxt = 1'b1;
          state_nxt        = S_IDLE;
        end else begin
          rem_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_status.done) begin
          if (rem_status.zero) begin
            // divisor found, composite
            out_valid_nxt    = 1'b1;
            out_is_prime_nxt = 1'b0;
            state_nxt        = S_IDLE;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_nxt    = sq_r + SQ_BITS'({d_r, 1'b1});
            d_nxt     = d_r + DIV_BITS'(1);
            state_nxt = S_CHECK;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      value_r <= in_value;
    end
    d_r            <= d_nxt;
    sq_r           <= sq_nxt;
    out_is_prime_r <= out_is_prime_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

endmodule

// ----- hw/rtl/tdp_rem.sv -----
// bit-serial restoring remainder unit, one dividend bit per cycle
// depends on tdp_pkg
`timescale 1ns / 1ps

module tdp_rem import tdp_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int DIV_BITS   = (VALUE_BITS + 1) / 2 + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [DIV_BITS-1:0]   divisor,
  output rem_status_t           status
);

  localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

  logic [CNT_BITS-1:0]   cnt_r;
  logic                  done_r;
  logic [VALUE_BITS-1:0] sh_r;
  logic [DIV_BITS-1:0]   rem_r;
  logic [DIV_BITS-1:0]   rem_nxt;
  logic [DIV_BITS:0]     trial;

  // shift next dividend bit into the partial remainder, subtract if it fits
  always_comb begin
    trial = {rem_r, sh_r[VALUE_BITS-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_nxt = DIV_BITS'(trial - {1'b0, divisor});
    end else begin
      rem_nxt = trial[DIV_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_BITS'(1));
      if (start) begin
        cnt_r <= CNT_BITS'(VALUE_BITS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      sh_r  <= sh_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign status.done = done_r;
  assign status.zero = (rem_r == '0);

endmodule

// ----- hw/rtl/tdp_checker.sv -----
// port-level checks for trial_division_prime_test, bound to the top level
// depends on trial_division_prime_test
`timescale 1ns / 1ps

module tdp_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // an accepted word keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a word");

  // the answer comes out as busy drops
  a_fall_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without an answer");

  // no answer while a word is still in work
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("answer shown while busy");

  // one single-cycle strobe per word
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("answer strobe longer than one cycle");

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
